// ===== src/bnlj_pkg.sv =====
// Shared types, codes and the key comparator for the block nested loop join.
// No dependencies; used by bnlj_cell and block_nested_loop_join.
`default_nettype none
package bnlj_pkg;

    // Operation codes carried in the input beat's tuser.
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_PROBE = 2'd2;

    // Comparison operator codes: outer key OP inner key.
    localparam logic [2:0] CMP_LT = 3'd0;
    localparam logic [2:0] CMP_GT = 3'd1;
    localparam logic [2:0] CMP_LE = 3'd2;
    localparam logic [2:0] CMP_GE = 3'd3;
    localparam logic [2:0] CMP_EQ = 3'd4;
    localparam logic [2:0] CMP_NE = 3'd5;

    localparam int          KEY_W      = 32;
    localparam int          TAG_W      = 32;
    localparam logic [2:0]  CMP_RESET  = CMP_EQ;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;   // capture the incoming outer row
        logic shift;  // take the neighbor's row this cycle
        logic wrap;   // this cell is the tail of the ring: take the head row
    } cell_ctrl_t;

    // Control state of the probe sequencer.
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } seq_state_t;

    // Compare an outer key with an inner key; unused codes never match.
    function automatic logic key_match(input logic [2:0]       op,
                                       input logic [KEY_W-1:0] outer_key,
                                       input logic [KEY_W-1:0] inner_key);
        logic signed [KEY_W-1:0] a;
        logic signed [KEY_W-1:0] b;
        logic                    res;
        a = $signed(outer_key);
        b = $signed(inner_key);
        case (op)
            CMP_LT:  res = (a < b);
            CMP_GT:  res = (a > b);
            CMP_LE:  res = (a <= b);
            CMP_GE:  res = (a >= b);
            CMP_EQ:  res = (a == b);
            CMP_NE:  res = (a != b);
            default: res = 1'b0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/bnlj_cell.sv =====
// One cell of the outer-row ring: holds a key and a tag, loads a new row,
// or takes its neighbor's row during a probe. Depends on bnlj_pkg.
`default_nettype none
module bnlj_cell (
    input  wire logic                         aclk,
    input  wire bnlj_pkg::cell_ctrl_t         ctrl,
    input  wire logic [bnlj_pkg::KEY_W-1:0]   load_key,
    input  wire logic [bnlj_pkg::TAG_W-1:0]   load_tag,
    input  wire logic [bnlj_pkg::KEY_W-1:0]   next_key,
    input  wire logic [bnlj_pkg::TAG_W-1:0]   next_tag,
    input  wire logic [bnlj_pkg::KEY_W-1:0]   head_key,
    input  wire logic [bnlj_pkg::TAG_W-1:0]   head_tag,
    output logic      [bnlj_pkg::KEY_W-1:0]   cell_key,
    output logic      [bnlj_pkg::TAG_W-1:0]   cell_tag
);

    logic [bnlj_pkg::KEY_W-1:0] key_reg;
    logic [bnlj_pkg::TAG_W-1:0] tag_reg;
    logic [bnlj_pkg::KEY_W-1:0] key_next;
    logic [bnlj_pkg::TAG_W-1:0] tag_next;

    // Select load, rotate from neighbor, wrap from head, or hold.
    always_comb begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.load) begin
            key_next = load_key;
            tag_next = load_tag;
        end else if (ctrl.shift) begin
            if (ctrl.wrap) begin
                key_next = head_key;
                tag_next = head_tag;
            end else begin
                key_next = next_key;
                tag_next = next_tag;
            end
        end
    end

    // Payload only, no reset.
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign cell_key = key_reg;
    assign cell_tag = tag_reg;

endmodule
`default_nettype wire

// ===== src/block_nested_loop_join.sv =====
// Block nested loop join: a ring of BLOCK_ROWS cells holds the outer block.
// A probe rotates the ring once, one outer row per cycle while the result stream
// is free, past the comparator at the head cell, then emits its last beat.
// A match is held until the next one or the end of the scan, and only then leaves.
// Reset (aresetn low, synchronous) empties the block, sets compare_op to eq, drops results.
`default_nettype none
module block_nested_loop_join #(
    parameter int BLOCK_ROWS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: compare_op
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_wdata,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] join_key, [63:32] row_tag
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] outer_tag, [63:32] inner_tag
    output logic [0:0]       m_tuser,   // [0] matched
    output logic             m_tlast
);

    localparam int FW = $clog2(BLOCK_ROWS + 1);
    localparam int KW = bnlj_pkg::KEY_W;
    localparam int TW = bnlj_pkg::TAG_W;

    // Ring of cells
    bnlj_pkg::cell_ctrl_t ctrl [BLOCK_ROWS];
    logic [KW-1:0]        cell_key [BLOCK_ROWS];
    logic [TW-1:0]        cell_tag [BLOCK_ROWS];

    // Control and payload registers
    bnlj_pkg::seq_state_t state_reg, state_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        cnt_reg, cnt_next;
    logic [2:0]           op_reg, op_next;
    logic                 pend_reg, pend_next;
    logic [TW-1:0]        pend_tag_reg, pend_tag_next;
    logic [KW-1:0]        ikey_reg, ikey_next;
    logic [TW-1:0]        itag_reg, itag_next;
    logic                 ovalid_reg, ovalid_next;
    logic [TW-1:0]        otag_reg, otag_next;
    logic [TW-1:0]        oitag_reg, oitag_next;
    logic                 omatch_reg, omatch_next;
    logic                 olast_reg, olast_next;

    logic          in_beat;
    logic          out_free;
    logic          do_load;
    logic          step;
    logic          head_hit;
    logic [KW-1:0] in_key;
    logic [TW-1:0] in_tag;

    assign in_key   = s_tdata[KW-1:0];
    assign in_tag   = s_tdata[KW+TW-1:KW];
    assign s_tready = aresetn && (state_reg == bnlj_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !ovalid_reg || m_tready;
    assign do_load  = in_beat && (s_tuser == bnlj_pkg::OP_LOAD) &&
                      (fill_reg < FW'(BLOCK_ROWS));
    assign step     = (state_reg == bnlj_pkg::ST_SCAN) && out_free;
    assign head_hit = bnlj_pkg::key_match(op_reg, cell_key[0], ikey_reg);

    // Build the ring; the last occupied cell wraps to the head.
    for (genvar i = 0; i < BLOCK_ROWS; i++) begin : g_cell
        logic [KW-1:0] nb_key;
        logic [TW-1:0] nb_tag;
        if (i == BLOCK_ROWS - 1) begin : g_tail
            assign nb_key = cell_key[0];
            assign nb_tag = cell_tag[0];
        end else begin : g_mid
            assign nb_key = cell_key[i+1];
            assign nb_tag = cell_tag[i+1];
        end
        assign ctrl[i].load  = do_load && (fill_reg == FW'(i));
        assign ctrl[i].shift = step;
        assign ctrl[i].wrap  = (fill_reg - FW'(1)) == FW'(i);

        bnlj_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl[i]),
            .load_key (in_key),
            .load_tag (in_tag),
            .next_key (nb_key),
            .next_tag (nb_tag),
            .head_key (cell_key[0]),
            .head_tag (cell_tag[0]),
            .cell_key (cell_key[i]),
            .cell_tag (cell_tag[i])
        );
    end

    // Sequencer: accept beats, scan the ring, hold one match to mark last.
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        cnt_next      = cnt_reg;
        op_next       = op_reg;
        pend_next     = pend_reg;
        pend_tag_next = pend_tag_reg;
        ikey_next     = ikey_reg;
        itag_next     = itag_reg;
        ovalid_next   = ovalid_reg && !m_tready;
        otag_next     = otag_reg;
        oitag_next    = oitag_reg;
        omatch_next   = omatch_reg;
        olast_next    = olast_reg;

        if (cfg_wen) begin
            op_next = cfg_wdata;
        end

        case (state_reg)
            bnlj_pkg::ST_IDLE: begin
                if (in_beat) begin
                    case (s_tuser)
                        bnlj_pkg::OP_CLEAR: fill_next = '0;
                        bnlj_pkg::OP_LOAD: begin
                            if (do_load) begin
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        bnlj_pkg::OP_PROBE: begin
                            ikey_next = in_key;
                            itag_next = in_tag;
                            cnt_next  = '0;
                            pend_next = 1'b0;
                            if (fill_reg == '0) begin
                                state_next = bnlj_pkg::ST_FLUSH;
                            end else begin
                                state_next = bnlj_pkg::ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            bnlj_pkg::ST_SCAN: begin
                if (step) begin
                    // Release the held match once a newer one turns up.
                    if (head_hit) begin
                        if (pend_reg) begin
                            ovalid_next = 1'b1;
                            otag_next   = pend_tag_reg;
                            oitag_next  = itag_reg;
                            omatch_next = 1'b1;
                            olast_next  = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_tag_next = cell_tag[0];
                    end
                    cnt_next = cnt_reg + FW'(1);
                    if (cnt_reg == fill_reg - FW'(1)) begin
                        state_next = bnlj_pkg::ST_FLUSH;
                    end
                end
            end
            bnlj_pkg::ST_FLUSH: begin
                // Emit the final result: held match, or the no-match beat.
                if (out_free) begin
                    ovalid_next = 1'b1;
                    otag_next   = pend_reg ? pend_tag_reg : '0;
                    oitag_next  = itag_reg;
                    omatch_next = pend_reg;
                    olast_next  = 1'b1;
                    state_next  = bnlj_pkg::ST_IDLE;
                end
            end
            default: state_next = bnlj_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bnlj_pkg::ST_IDLE;
            fill_reg   <= '0;
            cnt_reg    <= '0;
            op_reg     <= bnlj_pkg::CMP_RESET;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            cnt_reg    <= cnt_next;
            op_reg     <= op_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_tag_reg <= pend_tag_next;
        ikey_reg     <= ikey_next;
        itag_reg     <= itag_next;
        otag_reg     <= otag_next;
        oitag_reg    <= oitag_next;
        omatch_reg   <= omatch_next;
        olast_reg    <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {oitag_reg, otag_reg};
    assign m_tuser  = omatch_reg;
    assign m_tlast  = olast_reg;

`ifndef SYNTH
    // Block never holds more rows than it has cells.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(BLOCK_ROWS))
        else $error("fill count beyond block size");

    // Scan index stays inside the occupied part of the ring.
    a_scan_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bnlj_pkg::ST_SCAN) |-> (cnt_reg < fill_reg))
        else $error("scan index past fill count");

    // A probe of an empty block goes straight to the final beat.
    a_empty_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_tuser == bnlj_pkg::OP_PROBE && fill_reg == '0)
        |=> (state_reg == bnlj_pkg::ST_FLUSH))
        else $error("empty probe did not flush");

    // An unmatched result is always last and carries a zero outer tag.
    a_nomatch_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (ovalid_reg && !omatch_reg) |-> (olast_reg && otag_reg == '0))
        else $error("bad no-match result");
`endif

endmodule
`default_nettype wire
